### design/oscillatory_phase_integral_macros.svh
// Assertion macros used by the checker file.
`ifndef OSCILLATORY_PHASE_INTEGRAL_MACROS_SVH
`define OSCILLATORY_PHASE_INTEGRAL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OPI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define OPI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### design/opi_pkg.sv
// ----------------------------------------------------------------------------
// opi_pkg: shared types and constants
// Controller commands, datapath status, CORDIC table and fixed widths.
// ----------------------------------------------------------------------------
package opi_pkg;

	localparam int MAX_LOG2_POINTS = 16;
	localparam int PHASE_BITS      = 32;
	localparam int CORDIC_STEPS    = 30;
	localparam int ACC_W           = 52;
	localparam logic [4:0] K_RESET = 5'd10;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic init;
		logic setup;
		logic div_step;
		logic div_fix;
		logic cord_init;
		logic cord_step;
		logic accum;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic int_last;
		logic frac_last;
		logic rot_last;
		logic pt_last;
		logic kind;
		logic term2;
	} status_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] j);
		logic [31:0] v;
		case (j)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2F9;
			5'd15: v = 32'h0000517C;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A2F;
			5'd19: v = 32'h00000517;
			5'd20: v = 32'h0000028B;
			5'd21: v = 32'h00000145;
			5'd22: v = 32'h000000A2;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000028;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000002;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

### design/opi_ctrl.sv
// ----------------------------------------------------------------------------
// opi_ctrl: sequencing state machine
// Walks each term of each point through division, CORDIC and accumulation.
// ----------------------------------------------------------------------------
module opi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  opi_pkg::status_t st,
	output opi_pkg::cmd_t    cmd,
	output logic             busy
);
	import opi_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SETUP = 9'b000000010,
		S_DIV   = 9'b000000100,
		S_FIX   = 9'b000001000,
		S_FRAC  = 9'b000010000,
		S_CINIT = 9'b000100000,
		S_ROT   = 9'b001000000,
		S_ACC   = 9'b010000000,
		S_FIN   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   fin;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		fin     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.init = 1'b1;
					state_d  = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.int_last) state_d = S_FIX;
			end
			S_FIX: begin
				cmd.div_fix = 1'b1;
				state_d     = S_FRAC;
			end
			S_FRAC: begin
				cmd.div_step = 1'b1;
				if (st.frac_last) state_d = S_CINIT;
			end
			S_CINIT: begin
				cmd.cord_init = 1'b1;
				state_d       = S_ROT;
			end
			S_ROT: begin
				cmd.cord_step = 1'b1;
				if (st.rot_last) state_d = S_ACC;
			end
			S_ACC: begin
				cmd.accum = 1'b1;
				fin = st.pt_last && !(st.kind && !st.term2);
				if (fin) begin
					state_d = S_FIN;
				end else begin
					state_d = S_SETUP;
				end
			end
			S_FIN: begin
				// round the sums once the last term has landed
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

### design/opi_dp.sv
// ----------------------------------------------------------------------------
// opi_dp: phase, divider, CORDIC and accumulator datapath
// Executes controller commands; reports loop counters back as status.
// ----------------------------------------------------------------------------
module opi_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  opi_pkg::cmd_t      cmd,
	output opi_pkg::status_t   st,
	input  logic [4:0]         k_raw,
	input  logic               kind,
	input  logic signed [15:0] row_index,
	input  logic signed [15:0] col_index,
	output logic               done,
	output logic signed [31:0] real_part,
	output logic signed [31:0] imag_part
);
	import opi_pkg::*;

	logic               kind_q, term2_q, neg_q, flip_q, done_q;
	logic signed [15:0] m_q, n_q;
	logic [4:0]         k_q, j_q;
	logic [15:0]        i_q;
	logic [31:0]        numabs_q, quo_q, lin_q;
	logic [17:0]        den_q, rem_q;
	logic [5:0]         cnt_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [ACC_W-1:0] re_q, im_q;
	logic signed [31:0] re_out_q, im_out_q;

	logic [4:0]         k_clamp;
	logic [16:0]        pts, op;
	logic [17:0]        den_d;
	logic signed [33:0] prod_n;
	logic signed [33:0] prod_m;
	logic [32:0]        abs_n;
	logic [18:0]        trial;
	logic               ge;
	logic [31:0]        ph;
	logic signed [33:0] zs, sx, sy, at;
	logic signed [33:0] cx, cy;
	logic signed [ACC_W-1:0] t_re, t_im, v_re, v_im;
	logic [5:0]         fsh;
	logic               second;

	assign k_clamp = (k_raw < 5'd1) ? 5'd1 :
		(k_raw > 5'(MAX_LOG2_POINTS)) ? 5'(MAX_LOG2_POINTS) : k_raw;
	assign pts    = 17'd1 << k_q;
	assign second = kind_q && term2_q;

	always_comb begin
		if (!kind_q)     op = {1'b0, i_q};
		else if (!term2_q) op = pts;
		else             op = pts - {1'b0, i_q};
		den_d  = kind_q ? ({pts, 1'b0} - {2'b0, i_q}) : ({1'b0, pts} + {2'b0, i_q});
		prod_n = 34'(n_q) * $signed({17'b0, op});
		prod_m = 34'(m_q) * $signed({18'b0, i_q});
		abs_n  = prod_n[33] ? 33'(-prod_n) : 33'(prod_n);
	end

	assign trial = {rem_q, numabs_q[31]};
	assign ge    = (trial >= {1'b0, den_q});

	assign ph = quo_q - lin_q;
	assign zs = {{2{ph[31]}}, ph};
	assign sx = x_q >>> j_q;
	assign sy = y_q >>> j_q;
	assign at = $signed({2'b0, atan_turn(j_q)});
	assign cx = flip_q ? -x_q : x_q;
	assign cy = flip_q ? -y_q : y_q;

	assign fsh  = {1'b0, k_q} + 6'd1;
	assign t_re = re_q + (ACC_W'(1) <<< k_q);
	assign t_im = im_q + (ACC_W'(1) <<< k_q);
	assign v_re = t_re >>> fsh;
	assign v_im = t_im >>> fsh;

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			kind_q  <= kind;
			m_q     <= row_index;
			n_q     <= col_index;
			k_q     <= k_clamp;
			i_q     <= '0;
			term2_q <= 1'b0;
			re_q    <= '0;
			im_q    <= '0;
		end
		if (cmd.setup) begin
			numabs_q <= abs_n[31:0];
			neg_q    <= prod_n[33];
			den_q    <= den_d;
			lin_q    <= prod_m[31:0] << (6'd32 - {1'b0, k_q});
			rem_q    <= '0;
			quo_q    <= '0;
			cnt_q    <= '0;
		end
		if (cmd.div_step) begin
			numabs_q <= {numabs_q[30:0], 1'b0};
			rem_q    <= ge ? 18'(trial - {1'b0, den_q}) : trial[17:0];
			quo_q    <= {quo_q[30:0], ge};
			cnt_q    <= cnt_q + 6'd1;
		end
		if (cmd.div_fix && neg_q && (rem_q != '0)) begin
			rem_q <= den_q - rem_q;
		end
		if (cmd.cord_init) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			j_q <= '0;
			if (zs > 34'sd1073741824) begin
				z_q    <= zs - 34'sd2147483648;
				flip_q <= 1'b1;
			end else if (zs < -34'sd1073741824) begin
				z_q    <= zs + 34'sd2147483648;
				flip_q <= 1'b1;
			end else begin
				z_q    <= zs;
				flip_q <= 1'b0;
			end
		end
		if (cmd.cord_step) begin
			if (!z_q[33]) begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + at;
			end
			j_q <= j_q + 5'd1;
		end
		if (cmd.accum) begin
			if (second) begin
				re_q <= re_q - ACC_W'(cx);
				im_q <= im_q - ACC_W'(cy);
			end else begin
				re_q <= re_q + ACC_W'(cx);
				im_q <= im_q + ACC_W'(cy);
			end
			// advance to the second term, or to the next point
			if (kind_q && !term2_q) begin
				term2_q <= 1'b1;
			end else begin
				term2_q <= 1'b0;
				i_q     <= i_q + 16'd1;
			end
		end
		if (cmd.finish) begin
			re_out_q <= (v_re > 52'sd2147483647) ? 32'sh7FFFFFFF :
				(v_re < -52'sd2147483648) ? 32'sh80000000 : 32'(v_re);
			im_out_q <= (v_im > 52'sd2147483647) ? 32'sh7FFFFFFF :
				(v_im < -52'sd2147483648) ? 32'sh80000000 : 32'(v_im);
		end
	end

	// strobe done in the cycle after the sums are rounded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= cmd.finish;
	end

	assign st.int_last  = (cnt_q == 6'd31);
	assign st.frac_last = (cnt_q == 6'd63);
	assign st.rot_last  = (j_q == 5'(CORDIC_STEPS - 1));
	assign st.pt_last   = ({1'b0, i_q} == (pts - 17'd1));
	assign st.kind      = kind_q;
	assign st.term2     = term2_q;

	assign done      = done_q;
	assign real_part = re_out_q;
	assign imag_part = im_out_q;

endmodule

### design/oscillatory_phase_integral.sv
// ----------------------------------------------------------------------------
// oscillatory_phase_integral: Riemann sum of unit phasors over [0,1)
// Controller plus shared long divider and iterative CORDIC datapath.
// ----------------------------------------------------------------------------
// Sequence: after the start transfer, each point takes one term (plain) or two
//   terms (full); per term: setup, integer divide, fix, fraction divide,
//   CORDIC init and rotations, add; then the sums are rounded and done strobes.
// Throughput: one item at a time; busy stays high until the sums are rounded,
//   as the divider and CORDIC are shared across every term of every point.
// Reset: arst_n clears the state machine and the done strobe and loads k_raw_q
//   (log2 point count) with 10. Results are not held off: done lasts one cycle.
// ----------------------------------------------------------------------------
module oscillatory_phase_integral (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic signed [15:0] row_index,
	input  logic signed [15:0] col_index,
	output logic               done,
	output logic signed [31:0] real_part,
	output logic signed [31:0] imag_part,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data
);
	import opi_pkg::*;

	cmd_t       cmd;
	status_t    st;
	logic [4:0] k_raw_q;
	logic       ctrl_busy;

	// Register must be written only while idle (the block does not enforce this), so always take the transfer.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        k_raw_q <= K_RESET;
		else if (cfg_valid) k_raw_q <= cfg_data;
	end

	assign busy = ctrl_busy;

	// Sequencer: one term of one point at a time.
	opi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (ctrl_busy)
	);

	// Datapath: phase terms, long division, CORDIC, sums and rounding.
	opi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.k_raw     (k_raw_q),
		.kind      (kind),
		.row_index (row_index),
		.col_index (col_index),
		.done      (done),
		.real_part (real_part),
		.imag_part (imag_part)
	);

endmodule

### design/opi_checker.sv
// ----------------------------------------------------------------------------
// opi_checker: port-level assertions
// Checks the start / busy / done sequencing seen at the top level.
// ----------------------------------------------------------------------------
`include "oscillatory_phase_integral_macros.svh"

module opi_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	`OPI_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`OPI_ASSERT_NOW(a_done_idle, done, !busy)
	`OPI_ASSERT_NEXT(a_stay_idle, !busy && !start, !busy && !done)
	`OPI_ASSERT_NOW(a_done_after_busy, done, $past(busy))

endmodule

bind oscillatory_phase_integral opi_checker u_opi_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
